>>> design/scb_pkg.sv
`default_nettype none

package scb_pkg;

    // scanner modes
    typedef enum logic [2:0] {
        MODE_PLAIN  = 3'd0,
        MODE_BLOCK  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_SQUOTE = 3'd3,
        MODE_DQUOTE = 3'd4
    } scan_mode_t;

    // characters of interest
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;

    // output queue size, must be a power of two and at least 2
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // scanner state
    typedef struct packed {
        scan_mode_t mode;
        logic       slash_held;
        logic       star_before;
    } scan_state_t;

    // up to two result beats from one input beat
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       last;
    } scan_result_t;

endpackage

`default_nettype wire

>>> design/scb_scanner.sv
`default_nettype none

module scb_scanner
    import scb_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         advance,
    input  wire logic [7:0]   cur_byte,
    input  wire logic         cur_last,
    output scan_result_t      result
);

    scan_state_t state_reg;
    scan_state_t state_next;

    // state register, moves only when a beat is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{mode: MODE_PLAIN, slash_held: 1'b0, star_before: 1'b0};
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // classify one byte and build its results
    always_comb
    begin
        state_next   = state_reg;
        result.count = 2'd0;
        result.byte0 = cur_byte;
        result.byte1 = cur_byte;
        result.last  = cur_last;

        unique case (state_reg.mode)
            MODE_BLOCK:
            begin
                result.count = 2'd1;
                result.byte0 = CH_SPACE;
                if (state_reg.star_before && cur_byte == CH_SLASH)
                begin
                    state_next.mode        = MODE_PLAIN;
                    state_next.star_before = 1'b0;
                end
                else
                begin
                    state_next.star_before = (cur_byte == CH_STAR);
                end
            end
            MODE_LINE:
            begin
                result.count = 2'd1;
                result.byte0 = CH_SPACE;
                if (cur_byte == CH_NL)
                begin
                    state_next.mode = MODE_PLAIN;
                end
            end
            MODE_SQUOTE:
            begin
                result.count = 2'd1;
                if (cur_byte == CH_SQ)
                begin
                    state_next.mode = MODE_PLAIN;
                end
            end
            MODE_DQUOTE:
            begin
                result.count = 2'd1;
                if (cur_byte == CH_DQ)
                begin
                    state_next.mode = MODE_PLAIN;
                end
            end
            default:
            begin
                state_next.mode = MODE_PLAIN;
                if (state_reg.slash_held)
                begin
                    state_next.slash_held = 1'b0;
                    if (cur_byte == CH_STAR)
                    begin
                        result.count           = 2'd2;
                        result.byte0           = CH_SPACE;
                        result.byte1           = CH_SPACE;
                        state_next.mode        = MODE_BLOCK;
                        state_next.star_before = 1'b1;
                    end
                    else if (cur_byte == CH_SLASH)
                    begin
                        result.count    = 2'd2;
                        result.byte0    = CH_SPACE;
                        result.byte1    = CH_SPACE;
                        state_next.mode = MODE_LINE;
                    end
                    else
                    begin
                        // held slash was plain text, new byte follows it
                        result.count = 2'd2;
                        result.byte0 = CH_SLASH;
                        if (cur_byte == CH_SQ)
                        begin
                            state_next.mode = MODE_SQUOTE;
                        end
                        else if (cur_byte == CH_DQ)
                        begin
                            state_next.mode = MODE_DQUOTE;
                        end
                    end
                end
                else if (cur_byte == CH_SLASH)
                begin
                    state_next.slash_held = 1'b1;
                end
                else
                begin
                    result.count = 2'd1;
                    if (cur_byte == CH_SQ)
                    begin
                        state_next.mode = MODE_SQUOTE;
                    end
                    else if (cur_byte == CH_DQ)
                    begin
                        state_next.mode = MODE_DQUOTE;
                    end
                end
            end
        endcase

        // end of text: flush a held slash and return to reset
        if (cur_last)
        begin
            if (state_next.slash_held)
            begin
                result.count = 2'd1;
                result.byte0 = CH_SLASH;
            end
            state_next = '{mode: MODE_PLAIN, slash_held: 1'b0, star_before: 1'b0};
        end
    end

endmodule

`default_nettype wire

>>> design/scb_out_queue.sv
`default_nettype none

module scb_out_queue
    import scb_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire scan_result_t result,
    output logic              room,
    output logic [7:0]        out_byte,
    output logic              out_last,
    output logic              out_valid,
    input  wire logic         out_stall
);

    logic [8:0]          entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic [QUEUE_AW:0]   push_count;
    logic [QUEUE_AW-1:0] wr_ptr_plus1;
    logic                pop;

    // head of queue drives the output beat
    assign out_valid = (count_reg != '0);
    assign out_byte  = entry_reg[rd_ptr_reg][8:1];
    assign out_last  = entry_reg[rd_ptr_reg][0];
    assign pop       = out_valid && !out_stall;

    // two free slots needed to take any input beat
    assign room = (count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));

    assign push_count   = push ? {{(QUEUE_AW - 1){1'b0}}, result.count} : '0;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_count[QUEUE_AW-1:0];
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + push_count - {{QUEUE_AW{1'b0}}, pop};
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, last flag rides on the final beat of the group
    always_ff @(posedge clk)
    begin
        if (push && result.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= {result.byte0,
                                      result.last && (result.count == 2'd1)};
        end
        if (push && result.count == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= {result.byte1, result.last};
        end
    end

endmodule

`default_nettype wire

>>> design/source_comment_blanker.sv
`default_nettype none

// channel   direction  fields              handshake
// input     in         in_byte, in_last    in_valid / in_stall
// output    out        out_byte, out_last  out_valid / out_stall
//
// one input beat per cycle unless stalled; each beat yields zero, one or two
// output beats; a beat passes the input register, then the scanner and queue.
// a held slash gives no beat at first and two beats with the next byte.
// the four-entry output queue sets the stall: input stalls when fewer than
// two slots are free. reset clears scanner state and the queue.

module source_comment_blanker
    import scb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic [7:0]      out_byte,
    output logic            out_last,
    output logic            out_valid,
    input  wire logic       out_stall
);

    logic         in_vld_reg;
    logic         in_vld_next;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         room;
    logic         advance;
    logic         accept;
    scan_result_t result;

    // input register handshake
    assign advance  = in_vld_reg && room;
    assign in_stall = in_vld_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
    end

    // comment scanner
    scb_scanner u_scanner (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .cur_byte (in_byte_reg),
        .cur_last (in_last_reg),
        .result   (result)
    );

    // result queue
    scb_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .result    (result),
        .room      (room),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule

`default_nettype wire

>>> bench/source_comment_blanker_tb.sv
`timescale 1ns / 1ps

module source_comment_blanker_tb;

    import scb_pkg::*;

    // one byte of text with its end-of-text flag
    typedef struct packed {
        logic [7:0] b;
        logic       fin;
    } text_beat_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       in_last   = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_valid;
    logic       out_stall = 1'b0;

    text_beat_t text_q[$];
    text_beat_t blanked_q[$];
    text_beat_t want;
    text_beat_t next_beat;

    // scanner copy kept by the predictor
    scan_mode_t pm_mode     = MODE_PLAIN;
    logic       pm_slash    = 1'b0;
    logic       pm_star     = 1'b0;

    int  in_count   = 0;
    int  text_count = 0;
    int  out_count  = 0;
    int  mismatches = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;
    logic calm;

    source_comment_blanker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // no idling on either side for a while in the middle of the run
    assign calm = (in_count >= 550) && (in_count < 750);

    // expected output beats for one accepted input beat
    task automatic predict_blanked(input logic [7:0] b, input logic fin);
        logic [7:0] res [2];
        int n;
        n = 0;
        case (pm_mode)
            MODE_BLOCK:
            begin
                res[n] = CH_SPACE;
                n++;
                if (pm_star && b == CH_SLASH)
                begin
                    pm_mode = MODE_PLAIN;
                    pm_star = 1'b0;
                end
                else
                    pm_star = (b == CH_STAR);
            end
            MODE_LINE:
            begin
                res[n] = CH_SPACE;
                n++;
                if (b == CH_NL)
                    pm_mode = MODE_PLAIN;
            end
            MODE_SQUOTE:
            begin
                res[n] = b;
                n++;
                if (b == CH_SQ)
                    pm_mode = MODE_PLAIN;
            end
            MODE_DQUOTE:
            begin
                res[n] = b;
                n++;
                if (b == CH_DQ)
                    pm_mode = MODE_PLAIN;
            end
            default:
            begin
                pm_mode = MODE_PLAIN;
                if (pm_slash && (b == CH_STAR || b == CH_SLASH))
                begin
                    // held slash opens a comment, both bytes blanked
                    res[0] = CH_SPACE;
                    res[1] = CH_SPACE;
                    n = 2;
                    pm_slash = 1'b0;
                    if (b == CH_STAR)
                    begin
                        pm_mode = MODE_BLOCK;
                        pm_star = 1'b1;
                    end
                    else
                        pm_mode = MODE_LINE;
                end
                else
                begin
                    // a held slash that opens nothing comes out as is
                    if (pm_slash)
                    begin
                        res[n] = CH_SLASH;
                        n++;
                    end
                    pm_slash = (b == CH_SLASH);
                    if (b != CH_SLASH)
                    begin
                        res[n] = b;
                        n++;
                    end
                    if (b == CH_SQ)
                        pm_mode = MODE_SQUOTE;
                    else if (b == CH_DQ)
                        pm_mode = MODE_DQUOTE;
                end
            end
        endcase
        // end of text flushes a held slash and clears the scanner
        if (fin)
        begin
            if (pm_slash)
            begin
                res[n] = CH_SLASH;
                n++;
            end
            pm_mode  = MODE_PLAIN;
            pm_slash = 1'b0;
            pm_star  = 1'b0;
        end
        for (int k = 0; k < n; k++)
            blanked_q.push_back('{b: res[k], fin: fin && (k == n - 1)});
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_blanked(in_byte, in_last);
                in_count <= in_count + 1;
                if (in_last)
                    text_count <= text_count + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (text_q.size() != 0 && (calm || $urandom_range(0, 99) >= 6))
                begin
                    next_beat = text_q.pop_front();
                    in_valid <= 1'b1;
                    in_byte  <= next_beat.b;
                    in_last  <= next_beat.fin;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && in_count >= 300)
        begin
            out_stall <= 1'b1;
            hold_left <= 80;
            hold_done <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 6);
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            out_count <= out_count + 1;
            if (blanked_q.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual byte %02h last %0b",
                         $time, out_byte, out_last);
                mismatches++;
            end
            else
            begin
                want = blanked_q.pop_front();
                if (out_byte !== want.b)
                begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.b, out_byte);
                    mismatches++;
                end
                if (out_last !== want.fin)
                begin
                    $display("%0t: out_last expected %0b actual %0b",
                             $time, want.fin, out_last);
                    mismatches++;
                end
            end
        end
    end

    // one text from a string, last flag on its final byte
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back('{b: s[i], fin: (i == s.len() - 1)});
    endtask

    // random texts leaning on comment and quote characters
    task automatic add_random_texts(input int total);
        int len;
        int r;
        logic [7:0] c;
        while (total > 0)
        begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 18)
                    c = CH_SLASH;
                else if (r < 32)
                    c = CH_STAR;
                else if (r < 40)
                    c = CH_NL;
                else if (r < 46)
                    c = CH_SQ;
                else if (r < 52)
                    c = CH_DQ;
                else if (r < 57)
                    c = 8'($urandom_range(0, 255));
                else if (r < 65)
                    c = CH_SPACE;
                else
                    c = 8'h61 + 8'($urandom_range(0, 25));
                text_q.push_back('{b: c, fin: (i == len - 1)});
            end
            total -= len;
        end
    endtask

    // wait until the sender is drained and every result is back
    task automatic wait_drained();
        while (text_q.size() != 0 || in_valid || blanked_q.size() != 0)
            @(posedge clk);
    endtask

    // stimulus and end of run
    initial
    begin
        // lone slash flushed at end, byte extremes, slash-star-slash comment
        // then a star after the closing slash, held slash before other bytes
        add_text("/");
        text_q.push_back('{b: 8'h00, fin: 1'b1});
        text_q.push_back('{b: 8'hFF, fin: 1'b1});
        add_text("/*/*");
        add_text("a/b/");
        // line comment eats its newline, comments inside quotes pass,
        // unterminated double quote runs to the end
        add_text("//\n'/*'\"//");

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        wait_drained();
        add_random_texts(450);
        wait_drained();
        add_random_texts(450);
        wait_drained();
        repeat (10) @(posedge clk);

        $display("%0d input beats in %0d texts, %0d result beats compared",
                 in_count, text_count, out_count);
        $display("includes a long receiver hold-off and two full sender pauses");
        if (mismatches == 0)
            $display("source_comment_blanker_tb: clean");
        else
            $display("source_comment_blanker_tb: errors");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("timeout with %0d beats still expected", blanked_q.size());
        $display("source_comment_blanker_tb: errors");
        $finish;
    end

endmodule

>>> files.f
design/scb_pkg.sv
design/scb_scanner.sv
design/scb_out_queue.sv
design/source_comment_blanker.sv
bench/source_comment_blanker_tb.sv
